// ===== sv/e2q_pkg.sv =====
package e2q_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 16;

  localparam int ANGLE_W = 16;
  localparam int QUAT_W  = 16;
  localparam int ANG_W   = 33;
  localparam int CS_W    = 32;
  localparam int PROD_W  = 64;
  localparam int SUM_W   = 66;

  localparam logic signed [ANG_W-1:0] PI_Q30      = 33'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 33'sd1686629713;
  localparam logic signed [CS_W-1:0]  GAIN_Q30    = 32'sd652032874;
  localparam logic signed [SUM_W-1:0] OUT_MAX     = 66'sd16384;

  // atan(2^-idx) in q30, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_q30(input int idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      0:  v = 33'sd843314857;
      1:  v = 33'sd497837829;
      2:  v = 33'sd263043837;
      3:  v = 33'sd133525159;
      4:  v = 33'sd67021687;
      5:  v = 33'sd33543516;
      6:  v = 33'sd16775851;
      7:  v = 33'sd8388437;
      8:  v = 33'sd4194283;
      9:  v = 33'sd2097149;
      10: v = 33'sd1048576;
      default: begin
        if (idx <= 30) begin
          v = 33'sd1 <<< (30 - idx);
        end else begin
          v = '0;
        end
      end
    endcase
    return v;
  endfunction

endpackage

// ===== sv/e2q_cordic.sv =====
module e2q_cordic
  import e2q_pkg::*;
#(
  parameter int ITERATIONS = CORDIC_ITERATIONS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [ANGLE_W-1:0]  angle,
  output logic                       out_valid,
  output logic signed [CS_W-1:0]     cos_val,
  output logic signed [CS_W-1:0]     sin_val
);

  logic                     vld    [0:ITERATIONS];
  logic                     flip   [0:ITERATIONS];
  logic signed [CS_W-1:0]   x_pipe [0:ITERATIONS];
  logic signed [CS_W-1:0]   y_pipe [0:ITERATIONS];
  logic signed [ANG_W-1:0]  z_pipe [0:ITERATIONS];

  logic signed [ANG_W-1:0]  z_ext;
  logic signed [ANG_W-1:0]  z_fold;
  logic                     flip_fold;

  // half angle in q30 and fold by pi
  always_comb begin
    z_ext = {{(ANG_W-ANGLE_W-16){angle[ANGLE_W-1]}}, angle, 16'h0000};
    z_fold = z_ext;
    flip_fold = 1'b0;
    if (z_ext > HALF_PI_Q30) begin
      z_fold = z_ext - PI_Q30;
      flip_fold = 1'b1;
    end else if (z_ext < -HALF_PI_Q30) begin
      z_fold = z_ext + PI_Q30;
      flip_fold = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      x_pipe[0] <= GAIN_Q30;
      y_pipe[0] <= '0;
      z_pipe[0] <= z_fold;
      flip[0]   <= flip_fold;
    end
  end

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    localparam logic signed [ANG_W-1:0] ATAN = atan_q30(i);
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        flip[i+1] <= flip[i];
        if (!z_pipe[i][ANG_W-1]) begin
          x_pipe[i+1] <= x_pipe[i] - (y_pipe[i] >>> i);
          y_pipe[i+1] <= y_pipe[i] + (x_pipe[i] >>> i);
          z_pipe[i+1] <= z_pipe[i] - ATAN;
        end else begin
          x_pipe[i+1] <= x_pipe[i] + (y_pipe[i] >>> i);
          y_pipe[i+1] <= y_pipe[i] - (x_pipe[i] >>> i);
          z_pipe[i+1] <= z_pipe[i] + ATAN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[ITERATIONS];
    end
    if (en) begin
      cos_val <= flip[ITERATIONS] ? -x_pipe[ITERATIONS] : x_pipe[ITERATIONS];
      sin_val <= flip[ITERATIONS] ? -y_pipe[ITERATIONS] : y_pipe[ITERATIONS];
    end
  end

endmodule

// ===== sv/e2q_combine.sv =====
module e2q_combine
  import e2q_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [CS_W-1:0]    cr_in,
  input  logic signed [CS_W-1:0]    sr_in,
  input  logic signed [CS_W-1:0]    cp_in,
  input  logic signed [CS_W-1:0]    sp_in,
  input  logic signed [CS_W-1:0]    cy_in,
  input  logic signed [CS_W-1:0]    sy_in,
  output logic                      out_valid,
  output logic signed [QUAT_W-1:0]  w_out,
  output logic signed [QUAT_W-1:0]  x_out,
  output logic signed [QUAT_W-1:0]  y_out,
  output logic signed [QUAT_W-1:0]  z_out
);

  function automatic logic signed [CS_W-1:0] mul_q30(
    input logic signed [CS_W-1:0] a,
    input logic signed [CS_W-1:0] b
  );
    logic signed [PROD_W-1:0] p;
    p = a * b;
    p = (p + (64'sd1 <<< 29)) >>> 30;
    return CS_W'(p);
  endfunction

  function automatic logic signed [QUAT_W-1:0] to_out(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] r;
    r = (s + (66'sd1 <<< 45)) >>> 46;
    if (r > OUT_MAX) begin
      r = OUT_MAX;
    end else if (r < -OUT_MAX) begin
      r = -OUT_MAX;
    end
    return QUAT_W'(r);
  endfunction

  logic                    va, vb, vc;
  logic signed [CS_W-1:0]  cr_a, sr_a, cp_a, sp_a, cy_a, sy_a;
  logic signed [CS_W-1:0]  pa, pb, pc, pd, cy_b, sy_b;
  logic signed [PROD_W-1:0] tw1, tw2, tx1, tx2, ty1, ty2, tz1, tz2;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      out_valid <= vc;
    end
    if (en) begin
      // roll and pitch sines negated
      cr_a <= cr_in;
      sr_a <= -sr_in;
      cp_a <= cp_in;
      sp_a <= -sp_in;
      cy_a <= cy_in;
      sy_a <= sy_in;

      pa   <= mul_q30(cr_a, cp_a);
      pb   <= mul_q30(sr_a, sp_a);
      pc   <= mul_q30(sr_a, cp_a);
      pd   <= mul_q30(cr_a, sp_a);
      cy_b <= cy_a;
      sy_b <= sy_a;

      tw1 <= pa * cy_b;
      tw2 <= pb * sy_b;
      tx1 <= pc * cy_b;
      tx2 <= pd * sy_b;
      ty1 <= pd * cy_b;
      ty2 <= pc * sy_b;
      tz1 <= pa * sy_b;
      tz2 <= pb * cy_b;

      w_out <= to_out(SUM_W'(tw1) + SUM_W'(tw2));
      x_out <= to_out(SUM_W'(tx1) - SUM_W'(tx2));
      y_out <= to_out(SUM_W'(ty1) + SUM_W'(ty2));
      z_out <= to_out(SUM_W'(tz1) - SUM_W'(tz2));
    end
  end

endmodule

// ===== sv/euler_to_quaternion.sv =====
// Roll, pitch and yaw (signed Q3.13 radians) in, unit quaternion w, x, y, z (signed Q1.14,
// saturated to +-1.0) out, with the roll and pitch sines taken negated. One angle triple
// is accepted per cycle while in_stall is low, and every triple gives one quaternion
// through one input register, one fold stage, one CORDIC stage per iteration, one sign
// stage, and four stages of products, sums and rounding. The whole pipeline holds while
// out_stall is high with a result waiting; in_stall is high exactly then.
module euler_to_quaternion
  import e2q_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [ANGLE_W-1:0] roll_angle,
  input  logic signed [ANGLE_W-1:0] pitch_angle,
  input  logic signed [ANGLE_W-1:0] yaw_angle,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [QUAT_W-1:0]  quat_w,
  output logic signed [QUAT_W-1:0]  quat_x,
  output logic signed [QUAT_W-1:0]  quat_y,
  output logic signed [QUAT_W-1:0]  quat_z
);

  logic                      en;
  logic                      in_vld;
  logic signed [ANGLE_W-1:0] roll_r, pitch_r, yaw_r;
  logic                      cs_valid;
  logic signed [CS_W-1:0]    cr, sr, cp, sp, cy, sy;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (en) begin
      in_vld <= in_valid;
    end
    if (en) begin
      roll_r  <= roll_angle;
      pitch_r <= pitch_angle;
      yaw_r   <= yaw_angle;
    end
  end

  e2q_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_roll (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_vld),
    .angle     (roll_r),
    .out_valid (cs_valid),
    .cos_val   (cr),
    .sin_val   (sr)
  );

  e2q_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_pitch (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_vld),
    .angle     (pitch_r),
    .out_valid (),
    .cos_val   (cp),
    .sin_val   (sp)
  );

  e2q_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_yaw (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_vld),
    .angle     (yaw_r),
    .out_valid (),
    .cos_val   (cy),
    .sin_val   (sy)
  );

  e2q_combine u_combine (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cs_valid),
    .cr_in     (cr),
    .sr_in     (sr),
    .cp_in     (cp),
    .sp_in     (sp),
    .cy_in     (cy),
    .sy_in     (sy),
    .out_valid (out_valid),
    .w_out     (quat_w),
    .x_out     (quat_x),
    .y_out     (quat_y),
    .z_out     (quat_z)
  );

endmodule

// ===== bench/euler_to_quaternion_tb.sv =====
`timescale 1ns / 100ps

module euler_to_quaternion_tb;
  import e2q_pkg::*;

  localparam int CORDIC_STEPS = CORDIC_ITERATIONS_DEF;
  localparam int PIPE_LATENCY = CORDIC_STEPS + 7;
  localparam int HOLD_CYCLES = 300;
  localparam int STUCK_LIMIT = 2000;

  typedef struct {
    logic signed [ANGLE_W-1:0] roll;
    logic signed [ANGLE_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] yaw;
  } euler_t;

  typedef struct {
    logic signed [QUAT_W-1:0] w;
    logic signed [QUAT_W-1:0] x;
    logic signed [QUAT_W-1:0] y;
    logic signed [QUAT_W-1:0] z;
  } quat_t;

  localparam logic signed [ANGLE_W-1:0] EDGE_ANGLES [9] = '{
    16'sd0, 16'sd1, -16'sd1, 16'sd25735, 16'sd25736,
    -16'sd25735, -16'sd25736, 16'sd12868, -16'sd12868
  };

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [ANGLE_W-1:0] roll_angle = '0;
  logic signed [ANGLE_W-1:0] pitch_angle = '0;
  logic signed [ANGLE_W-1:0] yaw_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [QUAT_W-1:0] quat_w;
  logic signed [QUAT_W-1:0] quat_x;
  logic signed [QUAT_W-1:0] quat_y;
  logic signed [QUAT_W-1:0] quat_z;

  euler_t angle_pending[$];
  quat_t quat_expected[$];
  euler_t next_angles;
  quat_t quat_want;
  logic in_taken = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int holds_served = 0;
  int hold_left = 0;
  int stuck_cycles = 0;
  int mismatch_count = 0;

  euler_to_quaternion #(.CORDIC_ITERATIONS(CORDIC_STEPS)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .roll_angle(roll_angle),
    .pitch_angle(pitch_angle),
    .yaw_angle(yaw_angle),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .quat_w(quat_w),
    .quat_x(quat_x),
    .quat_y(quat_y),
    .quat_z(quat_z)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // arctangent of 2^-i in q30 from the series summed in q60
  function automatic longint atan_pow2(input int i);
    longint acc;
    longint term;
    int e;
    if (i == 0) begin
      return (longint'(PI_Q30) + 2) >>> 2;
    end
    acc = 0;
    for (int k = 0; 60 - i * (2 * k + 1) >= 0; k++) begin
      e = 60 - i * (2 * k + 1);
      term = (longint'(1) << e) / longint'(2 * k + 1);
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return (acc + (longint'(1) << 29)) >>> 30;
  endfunction

  function automatic void half_angle_cos_sin(input logic signed [ANGLE_W-1:0] a,
                                             output longint c, output longint s);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint da;
    bit flip;
    int n;
    z = longint'(a) * 65536;
    x = longint'(GAIN_Q30);
    y = 0;
    flip = 1'b0;
    n = CORDIC_STEPS;
    if (n < 1) begin
      n = 1;
    end
    if (n > 30) begin
      n = 30;
    end
    if (z > longint'(HALF_PI_Q30)) begin
      z = z - longint'(PI_Q30);
      flip = 1'b1;
    end else if (z < -longint'(HALF_PI_Q30)) begin
      z = z + longint'(PI_Q30);
      flip = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      da = atan_pow2(i);
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - da;
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + da;
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint mul_q30(input longint a, input longint b);
    return (a * b + (longint'(1) << 29)) >>> 30;
  endfunction

  function automatic logic signed [QUAT_W-1:0] round_q14(input longint sum_q60);
    longint v;
    v = (sum_q60 + (longint'(1) << 45)) >>> 46;
    if (v > 16384) begin
      v = 16384;
    end
    if (v < -16384) begin
      v = -16384;
    end
    return v[QUAT_W-1:0];
  endfunction

  function automatic quat_t predict_quaternion(input euler_t e);
    quat_t q;
    longint cr, sr, cp, sp, cy, sy;
    longint pa, pb, pc, pd;
    half_angle_cos_sin(e.roll, cr, sr);
    half_angle_cos_sin(e.pitch, cp, sp);
    half_angle_cos_sin(e.yaw, cy, sy);
    sr = -sr;
    sp = -sp;
    pa = mul_q30(cr, cp);
    pb = mul_q30(sr, sp);
    pc = mul_q30(sr, cp);
    pd = mul_q30(cr, sp);
    q.w = round_q14(pa * cy + pb * sy);
    q.x = round_q14(pc * cy - pd * sy);
    q.y = round_q14(pd * cy + pc * sy);
    q.z = round_q14(pa * sy - pb * cy);
    return q;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t: %s got %0d want %0d", $realtime, field, got, want);
    mismatch_count++;
  endtask

  function automatic logic signed [ANGLE_W-1:0] random_angle();
    int pick;
    pick = $urandom_range(9);
    if (pick <= 5) begin
      return ANGLE_W'($urandom_range(65535));
    end else if (pick <= 7) begin
      return ANGLE_W'($urandom_range(1024) - 512);
    end else if (pick == 8) begin
      return ($urandom_range(1) == 1) ? ANGLE_W'(25732 + $urandom_range(8))
                                      : ANGLE_W'(-25740 + $urandom_range(8));
    end
    return ($urandom_range(1) == 1) ? 16'sh7fff : 16'sh8000;
  endfunction

  task automatic queue_angles(input logic signed [ANGLE_W-1:0] r,
                              input logic signed [ANGLE_W-1:0] p,
                              input logic signed [ANGLE_W-1:0] y);
    euler_t e;
    e.roll = r;
    e.pitch = p;
    e.yaw = y;
    angle_pending = {angle_pending, e};
  endtask

  task automatic wait_all_done();
    while (angle_pending.size() != 0 || in_valid || quat_expected.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic run_phase(input int count, input int send_pct, input int stall_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      queue_angles(random_angle(), random_angle(), random_angle());
    end
    wait_all_done();
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (angle_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_angles = angle_pending.pop_front();
        in_valid <= 1'b1;
        roll_angle <= next_angles.roll;
        pitch_angle <= next_angles.pitch;
        yaw_angle <= next_angles.yaw;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_reqs) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        next_angles.roll = roll_angle;
        next_angles.pitch = pitch_angle;
        next_angles.yaw = yaw_angle;
        quat_expected = {quat_expected, predict_quaternion(next_angles)};
      end
      if (out_valid && !out_stall) begin
        if (quat_expected.size() == 0) begin
          report_mismatch("unexpected transfer quat_w", int'(quat_w), 0);
        end else begin
          quat_want = quat_expected.pop_front();
          if (quat_w !== quat_want.w) report_mismatch("quat_w", int'(quat_w), int'(quat_want.w));
          if (quat_x !== quat_want.x) report_mismatch("quat_x", int'(quat_x), int'(quat_want.x));
          if (quat_y !== quat_want.y) report_mismatch("quat_y", int'(quat_y), int'(quat_want.y));
          if (quat_z !== quat_want.z) report_mismatch("quat_z", int'(quat_z), int'(quat_want.z));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles = 0;
      end else if (in_valid || quat_expected.size() != 0) begin
        stuck_cycles = stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STUCK_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes of every field, fold boundaries and quarter turns
    for (int i = 0; i < 8; i++) begin
      queue_angles(i[0] ? 16'sh7fff : 16'sh8000, i[1] ? 16'sh7fff : 16'sh8000,
                   i[2] ? 16'sh7fff : 16'sh8000);
    end
    foreach (EDGE_ANGLES[i]) begin
      queue_angles(EDGE_ANGLES[i], EDGE_ANGLES[i], EDGE_ANGLES[i]);
    end
    queue_angles(16'sd25736, -16'sd25736, 16'sd12868);
    queue_angles(-16'sd12868, 16'sd25735, -16'sd1);
    queue_angles(16'sh7fff, 16'sd0, 16'sh8000);
    queue_angles(16'sd0, -16'sd25735, 16'sd25736);
    wait_all_done();

    run_phase(250, 0, 0);
    run_phase(250, 55, 0);
    run_phase(250, 0, 55);
    run_phase(250, 37, 37);

    // long output hold while input keeps coming
    @(posedge clk);
    hold_reqs = hold_reqs + 1;
    run_phase(150, 0, 0);

    run_phase(150, $urandom_range(60), $urandom_range(60));

    repeat (3 * PIPE_LATENCY) @(posedge clk);
    if (mismatch_count == 0 && quat_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
